// ===== design/b64c_pkg.sv =====
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types and character mapping functions for the base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  // One input transfer
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } b64c_in_t;

  // One result transfer
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_length;
  } b64c_out_t;

  // Six-bit value to alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Alphabet character to six-bit value; anything else maps to zero
  function automatic logic [5:0] char_sextet(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      t = 8'd62;
    end else if (c == 8'h2F) begin
      t = 8'd63;
    end
    return t[5:0];
  endfunction

endpackage

// ===== design/base64_codec_stream.sv =====
// ----------------------------------------------------------------------------
// base64_codec_stream
// Streaming base64 encoder/decoder, one byte per input transfer.
// A group-completing input shows its first result in the cycle after it is accepted.
// Throughput: one input per cycle, but an input that completes a group waits until the
// previous results have drained; the one-per-cycle drain of four characters holds encode back.
// Reset: async active low; clears mode, group position, pad flag, result valid.
// ----------------------------------------------------------------------------
module base64_codec_stream (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64c_pkg::b64c_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64c_pkg::b64c_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_decode_mode_i
);
  import b64c_pkg::*;

  // Gathering state
  logic       mode_q;
  logic [1:0] pos_q, pos_d;
  logic       tpad_q, tpad_d;
  logic [7:0] store_q [3];

  // Result register
  logic       res_valid_q;
  logic [7:0] res_byte_q [4];
  logic [7:0] res_byte_d [4];
  logic [1:0] res_idx_q;
  logic [1:0] res_end_q, res_end_d;
  logic       res_last_q;
  logic       res_bad_q, res_bad_d;

  logic       in_fire, out_fire, drain_end, buf_free, grp_done, cfg_fire;
  logic [7:0] b0, b1, b2;
  logic [5:0] s3;
  logic       pad4;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  // Output side
  assign out_valid_o         = res_valid_q;
  assign out_data_o.out_byte = res_byte_q[res_idx_q];
  assign out_data_o.out_last = res_last_q && (res_idx_q == res_end_q);
  assign out_data_o.bad_length = res_bad_q;

  assign out_fire  = out_valid_o && out_ready_i;
  assign drain_end = out_fire && (res_idx_q == res_end_q);
  assign buf_free  = !res_valid_q || drain_end;

  // Does this input produce results
  always_comb begin
    if (mode_q) begin
      grp_done = (pos_q == 2'd3) || in_data_i.in_last;
    end else begin
      grp_done = (pos_q == 2'd2) || in_data_i.in_last;
    end
  end

  assign in_ready_o = buf_free || !grp_done;
  assign in_fire    = in_valid_i && in_ready_o;

  // Group operands, current byte merged in
  assign b0   = (pos_q == 2'd0) ? in_data_i.in_byte : store_q[0];
  assign b1   = (pos_q == 2'd1) ? in_data_i.in_byte :
                ((pos_q == 2'd0) ? 8'h00 : store_q[1]);
  assign b2   = (pos_q == 2'd2) ? in_data_i.in_byte : 8'h00;
  assign s3   = char_sextet(in_data_i.in_byte);
  assign pad4 = (in_data_i.in_byte == PadChar);

  // Result formation and next gathering state
  always_comb begin
    pos_d      = pos_q + 2'd1;
    tpad_d     = tpad_q;
    res_end_d  = 2'd3;
    res_bad_d  = 1'b0;
    res_byte_d = '{default: 8'h00};
    if (!mode_q) begin
      res_byte_d[0] = sextet_char(b0[7:2]);
      res_byte_d[1] = sextet_char({b0[1:0], b1[7:4]});
      res_byte_d[2] = (pos_q != 2'd0) ? sextet_char({b1[3:0], b2[7:6]}) : PadChar;
      res_byte_d[3] = (pos_q == 2'd2) ? sextet_char(b2[5:0]) : PadChar;
      if (grp_done) begin
        pos_d = 2'd0;
      end
    end else if (pos_q != 2'd3) begin
      // Characters one to three; a result only if the stream ends inside the group
      res_end_d = 2'd0;
      res_bad_d = 1'b1;
      if (pos_q == 2'd2) begin
        tpad_d = pad4;
      end
      if (in_data_i.in_last) begin
        pos_d  = 2'd0;
        tpad_d = 1'b0;
      end
    end else begin
      res_byte_d[0] = {store_q[0][5:0], store_q[1][5:4]};
      res_byte_d[1] = {store_q[1][3:0], store_q[2][5:2]};
      res_byte_d[2] = {store_q[2][1:0], s3};
      res_end_d     = 2'd2 - {1'b0, pad4} - {1'b0, tpad_q};
      pos_d         = 2'd0;
      tpad_d        = 1'b0;
    end
  end

  // Gathering state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pos_q  <= 2'd0;
      tpad_q <= 1'b0;
    end else if (cfg_fire) begin
      mode_q <= cfg_decode_mode_i;
      pos_q  <= 2'd0;
      tpad_q <= 1'b0;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      tpad_q <= tpad_d;
    end
  end

  // Group store (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (in_fire && pos_q != 2'd3) begin
      store_q[pos_q] <= mode_q ? {2'b00, s3} : in_data_i.in_byte;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_idx_q   <= 2'd0;
    end else if (in_fire && grp_done) begin
      res_valid_q <= 1'b1;
      res_idx_q   <= 2'd0;
    end else if (drain_end) begin
      res_valid_q <= 1'b0;
      res_idx_q   <= 2'd0;
    end else if (out_fire) begin
      res_idx_q <= res_idx_q + 2'd1;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && grp_done) begin
      res_byte_q <= res_byte_d;
      res_end_q  <= res_end_d;
      res_last_q <= in_data_i.in_last;
      res_bad_q  <= res_bad_d;
    end
  end

`ifndef ASSERT_OFF
  // Transfer index never passes the last entry of the result
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_idx_q <= res_end_q))
    else $error("result index beyond end");

  // In encode mode a full group position is allowed only beside a held good result
  a_enc_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!mode_q && !res_bad_q && res_valid_q) || mode_q || (pos_q != 2'd3))
    else $error("encode group position overflow");

  // A length error is always a single, final transfer
  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_length) |-> (out_data_o.out_last && res_end_q == 2'd0))
    else $error("bad_length result not final");

  // A new group is loaded only when the result register is free
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && grp_done) |-> buf_free)
    else $error("result register overrun");
`endif

endmodule

// ===== tb/tb_base64_codec_stream.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_codec_stream
// Self-checking bench for the streaming base64 codec. A short table of
// directed transfers (padding, lone third pad, bad length, out-of-alphabet
// characters) is followed by random encode and decode messages. Every
// accepted result is checked against an in-bench model or typed bytes, under
// random idling, a long receiver hold-off and mode changes between phases.
// ----------------------------------------------------------------------------
module tb_base64_codec_stream;

  import b64c_pkg::*;

  localparam int          RandItems   = 300;
  localparam int          HoldCycles  = 100;  // receiver hold-off length
  localparam int          SettleCycles = 4;   // quiet time before a mode write
  localparam int unsigned StallLimit  = 1000; // cycles with no transfer at all
  localparam int          MaxPrints   = 30;

  // Index of a character in this string is its six-bit value
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  b64c_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  b64c_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_mode;

  base64_codec_stream DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .in_data_i        (in_data),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_o       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_decode_mode_i(cfg_mode)
  );

  // Directed stimulus row; typed results replace the model where given
  typedef struct {
    bit          mode;
    logic [7:0]  data;
    bit          last;
    int          n_typed;
    logic [31:0] typed_bytes;
    bit          typed_last;
    bit          typed_bad;
  } plan_row_t;

  plan_row_t   plan [$];
  b64c_out_t   pending_results [$];
  int          err_count = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          mode_now = 1'b0;

  // Typed results travelling with the item on offer
  int          offer_n_typed;
  logic [31:0] offer_typed_bytes;
  bit          offer_typed_last;
  bit          offer_typed_bad;

  // Codec model state
  bit         cm_decode = 1'b0;
  logic [7:0] cm_store [3] = '{8'h00, 8'h00, 8'h00};
  logic [1:0] cm_pos = 2'd0;
  bit         cm_third_pad = 1'b0;
  b64c_out_t  cm_out [4];
  int         cm_count;

  function automatic b64c_out_t mk_res(logic [7:0] b, logic l, logic bad);
    b64c_out_t r;
    r.out_byte   = b;
    r.out_last   = l;
    r.bad_length = bad;
    return r;
  endfunction

  function automatic logic [7:0] to_char(logic [5:0] v);
    return Alphabet[8*(63 - v) +: 8];
  endfunction

  // Linear search of the alphabet; unknown characters give zero
  function automatic logic [5:0] to_sextet(logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    for (int k = 0; k < 64; k++) begin
      if (Alphabet[8*(63 - k) +: 8] == c) v = 6'(k);
    end
    return v;
  endfunction

  function automatic void add_row(bit m, logic [7:0] d, bit l, int n = 0,
                                  logic [31:0] tb = '0, bit tl = 0, bit tbad = 0);
    plan_row_t r;
    r.mode = m;
    r.data = d;
    r.last = l;
    r.n_typed = n;
    r.typed_bytes = tb;
    r.typed_last = tl;
    r.typed_bad = tbad;
    plan.push_back(r);
  endfunction

  // Model: results caused by one accepted input transfer
  task automatic codec_step(input b64c_in_t it);
    int         n;
    int         cnt;
    logic [7:0] b0, b1, b2;
    logic [5:0] s0, s1, s2, s3;
    logic [7:0] d [3];
    cm_count = 0;
    if (!cm_decode) begin
      // encode: three bytes in, four characters out
      cm_store[cm_pos] = it.in_byte;
      n = int'(cm_pos) + 1;
      if (n < 3 && !it.in_last) begin
        cm_pos = 2'(n);
      end else begin
        b0 = cm_store[0];
        b1 = (n >= 2) ? cm_store[1] : 8'h00;
        b2 = (n >= 3) ? cm_store[2] : 8'h00;
        cm_out[0] = mk_res(to_char(b0[7:2]), 1'b0, 1'b0);
        cm_out[1] = mk_res(to_char({b0[1:0], b1[7:4]}), 1'b0, 1'b0);
        cm_out[2] = mk_res((n >= 2) ? to_char({b1[3:0], b2[7:6]}) : PadChar, 1'b0, 1'b0);
        cm_out[3] = mk_res((n >= 3) ? to_char(b2[5:0]) : PadChar, it.in_last, 1'b0);
        cm_count = 4;
        cm_pos = 2'd0;
      end
    end else if (cm_pos != 2'd3) begin
      // decode: gather characters one to three; a last one here is a bad length
      cm_store[cm_pos] = {2'b00, to_sextet(it.in_byte)};
      if (cm_pos == 2'd2) cm_third_pad = (it.in_byte == PadChar);
      if (it.in_last) begin
        cm_out[0] = mk_res(8'h00, 1'b1, 1'b1);
        cm_count = 1;
        cm_pos = 2'd0;
        cm_third_pad = 1'b0;
      end else begin
        cm_pos = cm_pos + 2'd1;
      end
    end else begin
      // decode: fourth character closes the group
      s0 = cm_store[0][5:0];
      s1 = cm_store[1][5:0];
      s2 = cm_store[2][5:0];
      s3 = to_sextet(it.in_byte);
      cnt = 3 - int'(it.in_byte == PadChar) - int'(cm_third_pad);
      d[0] = {s0, s1[5:4]};
      d[1] = {s1[3:0], s2[5:2]};
      d[2] = {s2[1:0], s3};
      for (int k = 0; k < cnt; k++) begin
        cm_out[k] = mk_res(d[k], (k == cnt - 1) ? it.in_last : 1'b0, 1'b0);
      end
      cm_count = cnt;
      cm_pos = 2'd0;
      cm_third_pad = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MaxPrints)
      $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  // Offer one input transfer; valid stays high afterwards until lowered
  task automatic send_item(input logic [7:0] b, input bit l, input int n = 0,
                           input logic [31:0] tb = '0, input bit tl = 0,
                           input bit tbad = 0);
    b64c_in_t it;
    it.in_byte = b;
    it.in_last = l;
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data           <= it;
    offer_n_typed     <= n;
    offer_typed_bytes <= tb;
    offer_typed_last  <= tl;
    offer_typed_bad   <= tbad;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every expected result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input bit m);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_mode  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_now = m;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  // Monitor: model update on input and config, check on output
  always @(posedge clk) begin
    b64c_out_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        cm_decode    = cfg_mode;
        cm_pos       = 2'd0;
        cm_third_pad = 1'b0;
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected, byte", out_data.out_byte, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data.out_byte, want.out_byte);
          if (out_data.out_last !== want.out_last)
            report_mismatch("out_last", out_data.out_last, want.out_last);
          if (out_data.bad_length !== want.bad_length)
            report_mismatch("bad_length", out_data.bad_length, want.bad_length);
        end
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        codec_step(in_data);
        if (offer_n_typed != 0) begin
          for (int k = 0; k < offer_n_typed; k++)
            pending_results.push_back(mk_res(
              offer_typed_bytes[8*(offer_n_typed - 1 - k) +: 8],
              offer_typed_last && (k == offer_n_typed - 1), offer_typed_bad));
        end else begin
          for (int k = 0; k < cm_count; k++) pending_results.push_back(cm_out[k]);
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int         rand_items;
    int         phase_end;
    int         phase;
    int         len;
    int         rem;
    int         cut;
    bit         m;
    logic [7:0] msg [$];

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data           = '0;
    cfg_valid         = 1'b0;
    cfg_mode          = 1'b0;
    offer_n_typed     = 0;
    offer_typed_bytes = '0;
    offer_typed_last  = 1'b0;
    offer_typed_bad   = 1'b0;

    // encode from reset: zero group, all-ones group, one-byte remainder
    add_row(0, 8'h00, 0);
    add_row(0, 8'h00, 0);
    add_row(0, 8'h00, 0, 4, "AAAA", 0);
    add_row(0, 8'hFF, 0);
    add_row(0, 8'hFF, 0);
    add_row(0, 8'hFF, 1, 4, "////", 1);
    add_row(0, 8'h4D, 1);
    add_row(0, 8'h11, 0);  // left partial, dropped by the mode write
    // decode: one pad, two pads, lone third pad
    add_row(1, "T", 0);
    add_row(1, "W", 0);
    add_row(1, "E", 0);
    add_row(1, "=", 0);
    add_row(1, "T", 0);
    add_row(1, "Q", 0);
    add_row(1, "=", 0);
    add_row(1, "=", 0);
    add_row(1, "T", 0);
    add_row(1, "Q", 0);
    add_row(1, "=", 0);
    add_row(1, "A", 0);
    // characters outside the alphabet all decode as zero
    add_row(1, 8'h00, 0);
    add_row(1, "*", 0);
    add_row(1, 8'hFF, 0);
    add_row(1, "~", 1, 3, 32'h0, 1);
    // stream ends after one character of a group
    add_row(1, "A", 1, 1, 32'h0, 1, 1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].mode != mode_now) set_mode(plan[i].mode);
      send_item(plan[i].data, plan[i].last, plan[i].n_typed, plan[i].typed_bytes,
                plan[i].typed_last, plan[i].typed_bad);
    end

    // Random phases, each opened by a mode write after a full drain
    rand_items = 0;
    phase = 0;
    while (rand_items < RandItems) begin
      m = (phase == 0) ? 1'b0 : 1'($urandom_range(1));
      set_mode(m);
      phase_end = rand_items + $urandom_range(30, 70);
      while (rand_items < phase_end) begin
        msg.delete();
        if (!mode_now) begin
          len = $urandom_range(1, 12);
          repeat (len) begin
            case ($urandom_range(9))
              0:       msg.push_back(8'h00);
              1:       msg.push_back(8'hFF);
              default: msg.push_back(8'($urandom_range(255)));
            endcase
          end
        end else begin
          // well-formed text for 1..9 bytes, then noise and truncation
          len = $urandom_range(1, 9);
          for (int g = 0; g < (len + 2) / 3; g++) begin
            rem = len - 3 * g;
            repeat (4) msg.push_back(to_char(6'($urandom_range(63))));
            if (rem == 1) begin
              msg[msg.size() - 2] = PadChar;
              msg[msg.size() - 1] = PadChar;
            end else if (rem == 2) begin
              msg[msg.size() - 1] = PadChar;
            end else if ($urandom_range(19) == 0) begin
              msg[msg.size() - 2] = PadChar;
            end
          end
          foreach (msg[k]) begin
            if ($urandom_range(99) < 6) msg[k] = 8'($urandom_range(255));
          end
          if ($urandom_range(99) < 12) begin
            cut = $urandom_range(1, 3);
            repeat (cut) if (msg.size() > 1) void'(msg.pop_back());
          end
        end
        foreach (msg[k]) begin
          send_item(msg[k], k == msg.size() - 1);
          rand_items++;
          calm = (rand_items >= 100 && rand_items < 170);
          if (rand_items == 40) hold_req = 1'b1;
        end
      end
      // sometimes leave a partial group for the next mode write to drop
      if ($urandom_range(2) == 0) begin
        len = $urandom_range(1, 2);
        repeat (len) begin
          send_item(8'($urandom_range(255)), 1'b0);
          rand_items++;
        end
      end
      phase++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/b64c_pkg.sv
design/base64_codec_stream.sv
tb/tb_base64_codec_stream.sv
